// ----- hw/rtl/hpc_pkg.sv -----
// ----------------------------------------------------------------------------
// hpc_pkg
// Shared types and constants of the Hamiltonian path counter.
// ----------------------------------------------------------------------------
package hpc_pkg;

  localparam int IdxW   = 4;
  localparam int RowW   = 9;
  localparam int CountW = 19;

  localparam logic [CountW-1:0] CountMax = 19'h7FFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage

// ----- hw/rtl/hpc_if.sv -----
// ----------------------------------------------------------------------------
// hpc_if
// Channel interfaces: adjacency row beats in, path count beats out.
// ----------------------------------------------------------------------------
interface hpc_row_if;
  logic                      valid;
  logic                      ready;
  logic [hpc_pkg::IdxW-1:0]  row_index;
  logic [hpc_pkg::RowW-1:0]  row_bits;
  logic                      last_row;

  modport source (output valid, output row_index, output row_bits, output last_row,
                  input ready);
  modport sink   (input valid, input row_index, input row_bits, input last_row,
                  output ready);
endinterface

interface hpc_cnt_if;
  logic                        valid;
  logic                        ready;
  logic [hpc_pkg::CountW-1:0]  path_count;

  modport source (output valid, output path_count, input ready);
  modport sink   (input valid, input path_count, output ready);
endinterface

// ----- hw/rtl/hamiltonian_path_counter.sv -----
// ----------------------------------------------------------------------------
// hamiltonian_path_counter
// Counts directed Hamiltonian paths with a subset-by-endpoint table.
// ----------------------------------------------------------------------------
// Usage:
//   in_row  : one adjacency row per beat (row_index, row_bits, last_row).
//             A row_index >= VERTICES stores nothing. A beat with last_row set
//             stores its row and starts a count run; in_row.ready stays low
//             until the run is finished.
//   out_cnt : one beat with path_count per last row, saturated at 2^19-1.
//   Table   : a run reads one table row (all endpoints of one subset) per
//             cycle, one read per nonempty subset and endpoint. The single
//             table read port sets this rate.
//   Stall   : the result sits in an output register; rows are accepted while
//             it waits. A following run finishes its table pass and then
//             holds until the waiting result has been taken.
//   Reset   : rst_n (synchronous) clears all rows to zero and empties the
//             output. The count table needs no clearing pass: every row is
//             written before its contents are used.
// ----------------------------------------------------------------------------
module hamiltonian_path_counter #(
  parameter int VERTICES = 9
) (
  input  logic         clk,
  input  logic         rst_n,
  hpc_row_if.sink      in_row,
  hpc_cnt_if.source    out_cnt
);

  function automatic longint unsigned fact(input int n);
    longint unsigned f;
    f = 1;
    for (int i = 2; i <= n; i++) begin
      f = f * longint'(i);
    end
    return f;
  endfunction

  localparam int UW      = $clog2(VERTICES);
  localparam int CntW    = $clog2(fact(VERTICES - 1) + 1);
  localparam int TotW    = CntW + UW;
  localparam int CmpW    = (TotW > hpc_pkg::CountW) ? TotW : hpc_pkg::CountW;
  localparam int HalfLo  = (VERTICES + 1) / 2;
  localparam int Subsets = 1 << VERTICES;

  typedef logic [VERTICES-1:0]           vset_t;
  typedef logic [VERTICES-1:0][CntW-1:0] row_t;

  typedef struct packed {
    logic           valid;
    vset_t          set;
    logic [UW-1:0]  u;
    logic           in_set;
    logic           single;
    logic           last;
    logic           full;
  } tag_t;

  localparam vset_t         FullSet = {VERTICES{1'b1}};
  localparam logic [UW-1:0] ULast   = UW'(VERTICES - 1);
  localparam logic [hpc_pkg::IdxW-1:0] VtxCnt = hpc_pkg::IdxW'(VERTICES);

  hpc_pkg::state_t state_r, state_nxt;

  vset_t          adj_r [VERTICES];
  vset_t          set_r;
  logic [UW-1:0]  u_r;
  tag_t           p1_r, p2_r;
  row_t           rd_data_r;
  row_t           row_buf_r, row_buf_nxt;
  logic [CntW-1:0] sum_lo_r, sum_hi_r;
  logic [CntW-1:0] sum_lo, sum_hi, cnt_val;
  logic [TotW-1:0] total_r, total_nxt;
  logic            out_valid_r;
  logic [hpc_pkg::CountW-1:0] out_count_r;

  row_t           mem [Subsets];

  logic           in_fire, issue, out_load, last_issue, run_done, wr_en;
  vset_t          u_bit, rd_addr;
  logic [CmpW-1:0] tot_ext;
  logic [hpc_pkg::CountW-1:0] count_sat;

  assign in_fire    = in_row.valid && in_row.ready;
  assign last_issue = (set_r == FullSet) && (u_r == '0);
  assign run_done   = p2_r.valid && p2_r.last && p2_r.full;
  assign u_bit      = vset_t'(1) << u_r;
  assign rd_addr    = set_r ^ u_bit;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hpc_pkg::ST_IDLE: begin
        if (in_fire && in_row.last_row) state_nxt = hpc_pkg::ST_RUN;
      end
      hpc_pkg::ST_RUN: begin
        if (last_issue) state_nxt = hpc_pkg::ST_DRAIN;
      end
      hpc_pkg::ST_DRAIN: begin
        if (run_done) state_nxt = hpc_pkg::ST_DONE;
      end
      hpc_pkg::ST_DONE: begin
        if (!out_valid_r || out_cnt.ready) state_nxt = hpc_pkg::ST_IDLE;
      end
      default: state_nxt = hpc_pkg::ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_row.ready = 1'b0;
    issue        = 1'b0;
    out_load     = 1'b0;
    unique case (state_r)
      hpc_pkg::ST_IDLE:  in_row.ready = 1'b1;
      hpc_pkg::ST_RUN:   issue = 1'b1;
      hpc_pkg::ST_DRAIN: ;
      hpc_pkg::ST_DONE:  out_load = !out_valid_r || out_cnt.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hpc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // adjacency rows
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int v = 0; v < VERTICES; v++) begin
        adj_r[v] <= '0;
      end
    end else if (in_fire && (in_row.row_index < VtxCnt)) begin
      adj_r[in_row.row_index[UW-1:0]] <= vset_t'(in_row.row_bits);
    end
  end

  // subset / endpoint walk; endpoints run downward so that row S is written
  // before the next subset reads it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_r <= '0;
      u_r   <= '0;
    end else if (in_fire && in_row.last_row) begin
      set_r <= vset_t'(1);
      u_r   <= ULast;
    end else if (issue) begin
      if (u_r == '0) begin
        set_r <= set_r + vset_t'(1);
        u_r   <= ULast;
      end else begin
        u_r <= u_r - UW'(1);
      end
    end
  end

  // count table
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[p2_r.set] <= row_buf_nxt;
    end
  end

  // pipeline tags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r.valid <= 1'b0;
      p2_r.valid <= 1'b0;
    end else begin
      p1_r.valid <= issue;
      p2_r.valid <= p1_r.valid;
    end
    p1_r.set    <= set_r;
    p1_r.u      <= u_r;
    p1_r.in_set <= set_r[u_r];
    p1_r.single <= (rd_addr == '0);
    p1_r.last   <= (u_r == '0);
    p1_r.full   <= (set_r == FullSet);
    p2_r.set    <= p1_r.set;
    p2_r.u      <= p1_r.u;
    p2_r.in_set <= p1_r.in_set;
    p2_r.single <= p1_r.single;
    p2_r.last   <= p1_r.last;
    p2_r.full   <= p1_r.full;
  end

  // stage 1: sum predecessors v with an edge v -> u, in two halves
  always_comb begin
    sum_lo = '0;
    sum_hi = '0;
    for (int v = 0; v < HalfLo; v++) begin
      if (adj_r[v][p1_r.u]) sum_lo = sum_lo + rd_data_r[v];
    end
    for (int v = HalfLo; v < VERTICES; v++) begin
      if (adj_r[v][p1_r.u]) sum_hi = sum_hi + rd_data_r[v];
    end
  end

  always_ff @(posedge clk) begin
    sum_lo_r <= sum_lo;
    sum_hi_r <= sum_hi;
  end

  // stage 2: entry value, row assembly, write-back and total
  always_comb begin
    if (!p2_r.in_set) begin
      cnt_val = '0;
    end else if (p2_r.single) begin
      cnt_val = CntW'(1);
    end else begin
      cnt_val = sum_lo_r + sum_hi_r;
    end
    row_buf_nxt = row_buf_r;
    row_buf_nxt[p2_r.u] = cnt_val;
    wr_en = p2_r.valid && p2_r.last;
    total_nxt = total_r;
    if (p2_r.valid && p2_r.full) total_nxt = total_r + TotW'(cnt_val);
  end

  always_ff @(posedge clk) begin
    if (p2_r.valid) begin
      row_buf_r <= row_buf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (in_fire && in_row.last_row) begin
      total_r <= '0;
    end else begin
      total_r <= total_nxt;
    end
  end

  // output register
  assign tot_ext   = CmpW'(total_r);
  assign count_sat = (tot_ext > CmpW'(hpc_pkg::CountMax)) ? hpc_pkg::CountMax
                                                           : hpc_pkg::CountW'(tot_ext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_cnt.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_count_r <= count_sat;
    end
  end

  assign out_cnt.valid      = out_valid_r;
  assign out_cnt.path_count = out_count_r;

endmodule

// ----- sim/hamiltonian_path_counter_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hamiltonian_path_counter_test
// Self-checking bench for the Hamiltonian path counter. Adjacency row beats
// go in with random gaps. Each row beat is mirrored into a subset-by-endpoint
// count kept by the bench, and every path count beat is checked against the
// oldest count still owed. Stimulus: a directed opening, then random graphs
// (tournaments, dense, sparse, random rows and partial reloads) mixed with
// noise beats. It also runs one long output stall and one full drain pause.
// ----------------------------------------------------------------------------
module hamiltonian_path_counter_test;

  localparam int Vertices   = 9;
  localparam int Subsets    = 1 << Vertices;
  localparam int FullSet    = Subsets - 1;
  localparam int Latency    = Vertices * Subsets + 5;
  localparam int TargetRows = 1170;
  localparam int LongHold   = 3 * (Latency + 200);
  localparam int MaxReports = 10;

  class count_ledger;
    logic [hpc_pkg::RowW-1:0]   adj [Vertices];
    logic [hpc_pkg::CountW-1:0] pending_counts [$];
    int matched;
    int errors;

    function new();
      foreach (adj[i]) adj[i] = '0;
      matched = 0;
      errors  = 0;
    endfunction

    function logic [hpc_pkg::CountW-1:0] tally_paths();
      int     ways [Subsets][Vertices];
      longint total;
      foreach (ways[s, v]) ways[s][v] = 0;
      for (int v = 0; v < Vertices; v++) ways[1 << v][v] = 1;
      for (int s = 1; s < Subsets; s++) begin
        for (int v = 0; v < Vertices; v++) begin
          if (!s[v] || ways[s][v] == 0) continue;
          for (int u = 0; u < Vertices; u++) begin
            if (!s[u] && adj[v][u]) ways[s | (1 << u)][u] += ways[s][v];
          end
        end
      end
      total = 0;
      for (int v = 0; v < Vertices; v++) total += ways[FullSet][v];
      if (total > hpc_pkg::CountMax) total = hpc_pkg::CountMax;
      return hpc_pkg::CountW'(total);
    endfunction

    function void note_row(logic [hpc_pkg::IdxW-1:0] idx, logic [hpc_pkg::RowW-1:0] bits,
                           logic last);
      if (idx < Vertices) adj[idx] = bits & hpc_pkg::RowW'(FullSet);
      if (last) pending_counts.push_back(tally_paths());
    endfunction

    function void flag(string what);
      errors++;
      if (errors <= MaxReports) $display("ERROR %s", what);
    endfunction

    function void check_count(logic [hpc_pkg::CountW-1:0] got);
      logic [hpc_pkg::CountW-1:0] want;
      if (pending_counts.size() == 0) begin
        flag($sformatf("unexpected path_count beat %0d", got));
      end else begin
        want = pending_counts.pop_front();
        if (got !== want) flag($sformatf("path_count expected %0d actual %0d", want, got));
        else matched++;
      end
    endfunction

    function int pending();
      return pending_counts.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  hpc_row_if row_ch ();
  hpc_cnt_if cnt_ch ();

  hamiltonian_path_counter #(.VERTICES(Vertices)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_row  (row_ch.sink),
    .out_cnt (cnt_ch.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  count_ledger     ledger = new();
  logic [hpc_pkg::RowW-1:0] graph_rows [Vertices];
  int              rows_sent = 0;
  int              tx_calm = 0;
  int              rx_calm = 0;
  bit              hold_request = 1'b0;

  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      calm = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  task automatic send_row(input logic [hpc_pkg::IdxW-1:0] idx,
                          input logic [hpc_pkg::RowW-1:0] bits, input logic last);
    int gap;
    gap = draw_gap(tx_calm);
    if (gap > 0) begin
      row_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    row_ch.row_index <= idx;
    row_ch.row_bits  <= bits;
    row_ch.last_row  <= last;
    row_ch.valid     <= 1'b1;
    do @(posedge clk); while (!row_ch.ready);
    ledger.note_row(idx, bits, last);
    rows_sent++;
  endtask

  // Loads n_rows of graph_rows in shuffled order; the last beat starts the count,
  // or with tail set an out-of-range index beat does.
  task automatic send_graph(input int n_rows, input bit tail);
    int order [Vertices];
    int j;
    int t;
    for (int i = 0; i < Vertices; i++) order[i] = i;
    for (int i = Vertices - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int k = 0; k < n_rows; k++) begin
      send_row(hpc_pkg::IdxW'(order[k]), graph_rows[order[k]],
               !tail && (k == n_rows - 1));
    end
    if (tail) send_row(hpc_pkg::IdxW'($urandom_range(Vertices, 15)),
                       hpc_pkg::RowW'($urandom_range(0, 511)), 1'b1);
  endtask

  // Result side: random ready gaps, one long hold on request.
  initial begin
    int gap;
    cnt_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = draw_gap(rx_calm);
      if (hold_request) begin
        hold_request = 1'b0;
        gap = LongHold;
      end
      if (gap > 0) begin
        cnt_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      cnt_ch.ready <= 1'b1;
      do @(posedge clk); while (!cnt_ch.valid);
      ledger.check_count(cnt_ch.path_count);
    end
  end

  initial begin
    int  pick;
    int  n;
    int  p;
    bit  paused;
    rst_n            <= 1'b0;
    row_ch.valid     <= 1'b0;
    row_ch.row_index <= '0;
    row_ch.row_bits  <= '0;
    row_ch.last_row  <= 1'b0;
    paused = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty graph straight from reset, counted through an out-of-range beat
    send_row(4'hF, 9'h1FF, 1'b1);
    // complete graph with self loops: 9! paths
    foreach (graph_rows[i]) graph_rows[i] = 9'h1FF;
    send_graph(Vertices, 1'b0);
    // out-of-range index stores nothing but recounts
    send_row(4'd9, 9'h000, 1'b1);
    // vertex 0 loses its out edges: only paths ending at 0 remain
    send_row(4'd0, 9'h000, 1'b0);
    send_row(4'd12, 9'h1FF, 1'b1);
    // single chain 0 -> 1 -> ... -> 8, last vertex with only a self loop
    for (int i = 0; i < Vertices - 1; i++) graph_rows[i] = hpc_pkg::RowW'(1 << (i + 1));
    graph_rows[Vertices - 1] = hpc_pkg::RowW'(1 << (Vertices - 1));
    send_graph(Vertices, 1'b0);

    hold_request = 1'b1;
    while (rows_sent < TargetRows) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        n = $urandom_range(3, 12);
        repeat (n) begin
          send_row(hpc_pkg::IdxW'($urandom_range(0, 15)),
                   hpc_pkg::RowW'($urandom_range(0, 511)),
                   $urandom_range(0, 9) == 0);
        end
      end else begin
        foreach (graph_rows[i]) graph_rows[i] = '0;
        if (pick < 40) begin
          for (int i = 0; i < Vertices; i++) begin
            for (int k = i + 1; k < Vertices; k++) begin
              if ($urandom_range(0, 1)) graph_rows[i][k] = 1'b1;
              else graph_rows[k][i] = 1'b1;
            end
          end
        end else if (pick < 55) begin
          p = $urandom_range(0, 100);
          foreach (graph_rows[i, k]) graph_rows[i][k] = ($urandom_range(0, 99) < p);
        end else if (pick < 65) begin
          foreach (graph_rows[i]) begin
            graph_rows[i] = 9'h1FF;
            repeat ($urandom_range(0, 3)) graph_rows[i][$urandom_range(0, Vertices - 1)] = 1'b0;
          end
        end else if (pick < 75) begin
          foreach (graph_rows[i]) begin
            repeat ($urandom_range(0, 3)) graph_rows[i][$urandom_range(0, Vertices - 1)] = 1'b1;
          end
        end else begin
          foreach (graph_rows[i]) graph_rows[i] = hpc_pkg::RowW'($urandom_range(0, 511));
        end
        if (pick >= 85) send_graph($urandom_range(1, 3), $urandom_range(0, 7) == 0);
        else send_graph(Vertices, $urandom_range(0, 7) == 0);
      end

      if (!paused && rows_sent >= TargetRows / 2 && ledger.pending() > 0) begin
        row_ch.valid <= 1'b0;
        while (ledger.pending() > 0) @(posedge clk);
        paused = 1'b1;
      end
    end
    row_ch.valid <= 1'b0;

    while (ledger.pending() > 0) @(posedge clk);
    repeat (Latency + 200) @(posedge clk);

    $display("Sent %0d row beats; %0d path counts matched, %0d errors.",
             rows_sent, ledger.matched, ledger.errors);
    $display("Covered tournaments, dense/sparse/random graphs, partial reloads, noise, stalls.");
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("hamiltonian_path_counter verification clean");
    end else begin
      if (ledger.pending() > 0) $display("ERROR %0d path counts never arrived", ledger.pending());
      $display("hamiltonian_path_counter verification failed");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("ERROR timeout");
    $display("hamiltonian_path_counter verification failed");
    $finish;
  end

endmodule
